[rtl/lbgk_pkg.sv]
`default_nettype none

package lbgk_pkg;

   localparam int FIELD_W       = 24;
   localparam int NDIR          = 9;
   localparam int FRAC_BITS_DEF = 20;
   localparam int RELAX_W       = 18;
   localparam int ITEMP_W       = 20;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 20;
   localparam int SUM_W         = FIELD_W + 4;
   localparam int NU_SHIFT      = 16;
   localparam int IT_SHIFT      = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RELAX = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ITEMP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 2'd2;

   localparam logic [RELAX_W-1:0] RELAX_RESET = 18'd65536;
   localparam logic [ITEMP_W-1:0] ITEMP_RESET = 20'd196608;

   localparam logic EQ_QUADRATIC = 1'b0;
   localparam logic EQ_LINEAR    = 1'b1;

   // d2q9 velocity set, weights as shift of 1/36
   localparam logic signed [1:0] DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
   localparam logic signed [1:0] DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
   localparam int W_SHIFT [NDIR] = '{4, 2, 2, 2, 2, 0, 0, 0, 0};

   // division by nine as multiply by reciprocal
   localparam int               T_W         = FIELD_W + 4;
   localparam logic [31:0]      RECIP9      = 32'd3817748708;
   localparam int               RECIP_SHIFT = 35;
   localparam logic [T_W-1:0]   FEQ_CLIP    = 28'd150994944;

   typedef struct packed {
      logic signed [FIELD_W-1:0] pop_0;
      logic signed [FIELD_W-1:0] pop_1;
      logic signed [FIELD_W-1:0] pop_2;
      logic signed [FIELD_W-1:0] pop_3;
      logic signed [FIELD_W-1:0] pop_4;
      logic signed [FIELD_W-1:0] pop_5;
      logic signed [FIELD_W-1:0] pop_6;
      logic signed [FIELD_W-1:0] pop_7;
      logic signed [FIELD_W-1:0] pop_8;
   } req_payload_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] new_pop_0;
      logic signed [FIELD_W-1:0] new_pop_1;
      logic signed [FIELD_W-1:0] new_pop_2;
      logic signed [FIELD_W-1:0] new_pop_3;
      logic signed [FIELD_W-1:0] new_pop_4;
      logic signed [FIELD_W-1:0] new_pop_5;
      logic signed [FIELD_W-1:0] new_pop_6;
      logic signed [FIELD_W-1:0] new_pop_7;
      logic signed [FIELD_W-1:0] new_pop_8;
      logic signed [FIELD_W-1:0] density;
      logic signed [FIELD_W-1:0] velocity_x;
      logic signed [FIELD_W-1:0] velocity_y;
   } rsp_payload_type;

   function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd8388607;
      lo = -64'sd8388608;
      if (v > hi) begin
         return FIELD_W'(hi);
      end else if (v < lo) begin
         return FIELD_W'(lo);
      end
      return FIELD_W'(v);
   endfunction

endpackage

`default_nettype wire

[rtl/lattice_bgk_collision_d2q9_core.sv]
`default_nettype none

// d2q9 bgk collision, one lattice node per transaction
// request: req_payload carries the nine distributions pop_0..pop_8 (signed fixed point)
// response: rsp_payload carries the nine relaxed distributions, density and velocity
// both channels: a transaction completes on a clock edge with valid high and stall low
// csr port: csr_wr_en writes csr_wdata into register csr_index (0 relax factor,
//   1 inverse temperature, 2 equilibrium mode); the user writes them only while no
//   transaction is in flight, and the block itself does not enforce this
// throughput: one node per cycle while no response is held under rsp_stall; nine
//   lanes run the equilibrium and relaxation in parallel behind two 25-stage pipelined
//   dividers for the velocity (a sign and range stage, then one quotient bit per stage)
// the whole pipeline advances together; while a response waits under rsp_stall the
//   pipeline holds and req_stall is raised, and bubbles still move when nothing waits
// reset: synchronous, clears every valid flag and loads the register reset values
module lattice_bgk_collision_d2q9_core #(
   parameter int FRAC_BITS = lbgk_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire lbgk_pkg::req_payload_type           req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output lbgk_pkg::rsp_payload_type                rsp_payload,
   input  wire logic                                csr_wr_en,
   input  wire logic [lbgk_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [lbgk_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lbgk_pkg::*;

   localparam int DIV_LAT  = FIELD_W + 1;
   localparam int LANE_LAT = 9;
   localparam int DEPTH    = 1 + DIV_LAT + 1 + LANE_LAT;
   localparam int SQ_W     = 2 * FIELD_W + 1;
   localparam int SS_W     = SQ_W - FRAC_BITS;
   localparam int UP_W     = SS_W + ITEMP_W;
   localparam int UQ_W     = UP_W - IT_SHIFT;

   typedef struct packed {
      req_payload_type           pops;
      logic signed [FIELD_W-1:0] rho;
   } node_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] rho;
      logic signed [FIELD_W-1:0] ux;
      logic signed [FIELD_W-1:0] uy;
   } moment_type;

   // configuration registers
   logic [RELAX_W-1:0] relax_ff, relax_in;
   logic [ITEMP_W-1:0] itemp_ff, itemp_in;
   logic               mode_ff, mode_in;

   // pipeline control
   logic               en;
   logic [DEPTH-1:0]   vld_ff, vld_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // accept stage: sums
   logic signed [SUM_W-1:0] rho_sum, mx_sum, my_sum;
   logic signed [SUM_W-1:0] a_rho_ff, a_mx_ff, a_my_ff;
   req_payload_type         a_pops_ff;

   // divider alignment and velocity stage
   node_type                  dly_ff [0:DIV_LAT-1];
   logic signed [FIELD_W-1:0] ux_div, uy_div;
   node_type                  u_node_ff;
   logic signed [FIELD_W-1:0] u_ux_ff, u_uy_ff;
   logic signed [FIELD_W-1:0] u_pop [NDIR];

   // shared speed-squared path
   logic signed [2*FIELD_W-1:0] sqx_ff, sqy_ff;
   logic [SS_W-1:0]             ssum_ff;
   logic [UP_W-1:0]             usq_prod_ff;
   logic [UQ_W-1:0]             usq;

   // moments carried past the lanes
   moment_type                  mom_ff [1:LANE_LAT];
   logic signed [FIELD_W-1:0]   new_pop [NDIR];
   rsp_payload_type             rsp_payload_ff, rsp_payload_in;

   // the pipeline moves unless a response sits stalled at the output
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // register writes, unknown index ignored
   always_comb begin
      relax_in = relax_ff;
      itemp_in = itemp_ff;
      mode_in  = mode_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_RELAX: relax_in = RELAX_W'(csr_wdata);
            CSR_ITEMP: itemp_in = ITEMP_W'(csr_wdata);
            CSR_MODE:  mode_in  = csr_wdata[0];
            default:   ;
         endcase
      end
   end

   // valid flags shift with the payload
   always_comb begin
      vld_in       = vld_ff;
      rsp_valid_in = rsp_valid_ff;
      if (en) begin
         vld_in       = {vld_ff[DEPTH-2:0], req_valid};
         rsp_valid_in = vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relax_ff     <= RELAX_RESET;
         itemp_ff     <= ITEMP_RESET;
         mode_ff      <= EQ_QUADRATIC;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         relax_ff     <= relax_in;
         itemp_ff     <= itemp_in;
         mode_ff      <= mode_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // density and momentum sums
   assign rho_sum = SUM_W'(req_payload.pop_0) + SUM_W'(req_payload.pop_1)
                  + SUM_W'(req_payload.pop_2) + SUM_W'(req_payload.pop_3)
                  + SUM_W'(req_payload.pop_4) + SUM_W'(req_payload.pop_5)
                  + SUM_W'(req_payload.pop_6) + SUM_W'(req_payload.pop_7)
                  + SUM_W'(req_payload.pop_8);
   assign mx_sum  = SUM_W'(req_payload.pop_1) - SUM_W'(req_payload.pop_3)
                  + SUM_W'(req_payload.pop_5) - SUM_W'(req_payload.pop_6)
                  - SUM_W'(req_payload.pop_7) + SUM_W'(req_payload.pop_8);
   assign my_sum  = SUM_W'(req_payload.pop_2) - SUM_W'(req_payload.pop_4)
                  + SUM_W'(req_payload.pop_5) + SUM_W'(req_payload.pop_6)
                  - SUM_W'(req_payload.pop_7) - SUM_W'(req_payload.pop_8);

   always_ff @(posedge clock) begin
      if (en) begin
         a_rho_ff  <= rho_sum;
         a_mx_ff   <= mx_sum;
         a_my_ff   <= my_sum;
         a_pops_ff <= req_payload;
      end
   end

   // velocity = momentum / density, zero density gives zero
   lbgk_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock (clock),
      .en    (en),
      .num   (a_mx_ff),
      .den   (a_rho_ff),
      .quo   (ux_div)
   );

   lbgk_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock (clock),
      .en    (en),
      .num   (a_my_ff),
      .den   (a_rho_ff),
      .quo   (uy_div)
   );

   // distributions and saturated density wait alongside the dividers
   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0].pops <= a_pops_ff;
         dly_ff[0].rho  <= sat_field(64'(a_rho_ff));
         for (int i = 1; i < DIV_LAT; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
         u_node_ff <= dly_ff[DIV_LAT-1];
         u_ux_ff   <= ux_div;
         u_uy_ff   <= uy_div;
      end
   end

   // squared speed, shared by all lanes, ready when the lanes reach the equilibrium
   assign usq = UQ_W'(usq_prod_ff >> IT_SHIFT);

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff      <= (2*FIELD_W)'(u_ux_ff) * (2*FIELD_W)'(u_ux_ff);
         sqy_ff      <= (2*FIELD_W)'(u_uy_ff) * (2*FIELD_W)'(u_uy_ff);
         ssum_ff     <= SS_W'((SQ_W'(unsigned'(sqx_ff)) + SQ_W'(unsigned'(sqy_ff)))
                              >> FRAC_BITS);
         usq_prod_ff <= UP_W'(ssum_ff) * UP_W'(itemp_ff);
      end
   end

   assign u_pop[0] = u_node_ff.pops.pop_0;
   assign u_pop[1] = u_node_ff.pops.pop_1;
   assign u_pop[2] = u_node_ff.pops.pop_2;
   assign u_pop[3] = u_node_ff.pops.pop_3;
   assign u_pop[4] = u_node_ff.pops.pop_4;
   assign u_pop[5] = u_node_ff.pops.pop_5;
   assign u_pop[6] = u_node_ff.pops.pop_6;
   assign u_pop[7] = u_node_ff.pops.pop_7;
   assign u_pop[8] = u_node_ff.pops.pop_8;

   // one lane per direction
   for (genvar d = 0; d < NDIR; d++) begin : g_lane
      lbgk_lane #(.FRAC_BITS(FRAC_BITS), .LANE(d)) u_lane (
         .clock   (clock),
         .en      (en),
         .pop     (u_pop[d]),
         .ux      (u_ux_ff),
         .uy      (u_uy_ff),
         .rho     (u_node_ff.rho),
         .usq     (usq),
         .itemp   (itemp_ff),
         .relax   (relax_ff),
         .mode    (mode_ff),
         .new_pop (new_pop[d])
      );
   end

   // density and velocity follow the lanes to the output
   always_ff @(posedge clock) begin
      if (en) begin
         mom_ff[1].rho <= u_node_ff.rho;
         mom_ff[1].ux  <= u_ux_ff;
         mom_ff[1].uy  <= u_uy_ff;
         for (int i = 2; i <= LANE_LAT; i++) begin
            mom_ff[i] <= mom_ff[i-1];
         end
      end
   end

   // merge lanes and moments into the response register
   always_comb begin
      rsp_payload_in.new_pop_0  = new_pop[0];
      rsp_payload_in.new_pop_1  = new_pop[1];
      rsp_payload_in.new_pop_2  = new_pop[2];
      rsp_payload_in.new_pop_3  = new_pop[3];
      rsp_payload_in.new_pop_4  = new_pop[4];
      rsp_payload_in.new_pop_5  = new_pop[5];
      rsp_payload_in.new_pop_6  = new_pop[6];
      rsp_payload_in.new_pop_7  = new_pop[7];
      rsp_payload_in.new_pop_8  = new_pop[8];
      rsp_payload_in.density    = mom_ff[LANE_LAT].rho;
      rsp_payload_in.velocity_x = mom_ff[LANE_LAT].ux;
      rsp_payload_in.velocity_y = mom_ff[LANE_LAT].uy;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // back-pressure only comes from a stalled response
   assert property (@(posedge clock) disable iff (reset) !rsp_stall |-> !req_stall)
      else $error("request stalled without response back-pressure");

   // nothing comes out straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // zero density always carries zero velocity
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.density == '0) |->
      (rsp_payload.velocity_x == '0 && rsp_payload.velocity_y == '0))
      else $error("nonzero velocity with zero density");

   // a relax factor write lands in the register
   assert property (@(posedge clock) disable iff (reset)
      (csr_wr_en && csr_index == CSR_RELAX) |=> relax_ff == $past(RELAX_W'(csr_wdata)))
      else $error("relax factor write lost");

   // a held response stays valid and the valid flags hold while the pipeline is frozen
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(vld_ff)))
      else $error("pipeline moved under a stalled response");

endmodule

`default_nettype wire

[rtl/lbgk_div.sv]
`default_nettype none

module lbgk_div #(
   parameter int FRAC_BITS = lbgk_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                en,
   input  wire logic signed [lbgk_pkg::SUM_W-1:0]   num,
   input  wire logic signed [lbgk_pkg::SUM_W-1:0]   den,
   output logic signed [lbgk_pkg::FIELD_W-1:0]      quo
);
   import lbgk_pkg::*;

   localparam int NW = SUM_W + FRAC_BITS;
   localparam int QW = FIELD_W;
   localparam int CW = NW + QW;

   logic [SUM_W-1:0] num_abs;
   logic [SUM_W-1:0] den_abs;
   logic [NW-1:0]    rem0;

   logic [NW-1:0]    rem_ff  [0:QW];
   logic [SUM_W-1:0] den_ff  [0:QW];
   logic [QW-1:0]    q_ff    [0:QW];
   logic             neg_ff  [0:QW];
   logic             ovf_ff  [0:QW];
   logic             zero_ff [0:QW];

   logic signed [QW+1:0] qs;

   assign num_abs = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
   assign den_abs = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
   assign rem0    = {num_abs, {FRAC_BITS{1'b0}}};

   // sign, overflow and zero checks ahead of the bit stages
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem0;
         den_ff[0]  <= den_abs;
         q_ff[0]    <= '0;
         neg_ff[0]  <= num[SUM_W-1] ^ den[SUM_W-1];
         ovf_ff[0]  <= CW'(rem0) >= (CW'(den_abs) << QW);
         zero_ff[0] <= (den == '0);
      end
   end

   // one quotient bit per stage, restoring
   for (genvar k = 0; k < QW; k++) begin : g_bit
      localparam int BIT = QW - 1 - k;
      logic [CW-1:0] shifted;
      logic [CW-1:0] rem_x;
      logic          take;

      assign shifted = CW'(den_ff[k]) << BIT;
      assign rem_x   = CW'(rem_ff[k]);
      assign take    = rem_x >= shifted;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= take ? NW'(rem_x - shifted) : rem_ff[k];
            q_ff[k+1]    <= q_ff[k] | (take ? (QW'(1) << BIT) : '0);
            den_ff[k+1]  <= den_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            ovf_ff[k+1]  <= ovf_ff[k];
            zero_ff[k+1] <= zero_ff[k];
         end
      end
   end

   assign qs = neg_ff[QW] ? -$signed({2'b00, q_ff[QW]}) : $signed({2'b00, q_ff[QW]});

   always_comb begin
      if (zero_ff[QW]) begin
         quo = '0;
      end else if (ovf_ff[QW]) begin
         quo = neg_ff[QW] ? sat_field(-64'sd9000000) : sat_field(64'sd9000000);
      end else begin
         quo = sat_field(64'(qs));
      end
   end

endmodule

`default_nettype wire

[rtl/lbgk_lane.sv]
`default_nettype none

module lbgk_lane #(
   parameter int FRAC_BITS = lbgk_pkg::FRAC_BITS_DEF,
   parameter int LANE      = 0
) (
   input  wire logic                                          clock,
   input  wire logic                                          en,
   input  wire logic signed [lbgk_pkg::FIELD_W-1:0]           pop,
   input  wire logic signed [lbgk_pkg::FIELD_W-1:0]           ux,
   input  wire logic signed [lbgk_pkg::FIELD_W-1:0]           uy,
   input  wire logic signed [lbgk_pkg::FIELD_W-1:0]           rho,
   input  wire logic [2*lbgk_pkg::FIELD_W+1-FRAC_BITS+lbgk_pkg::ITEMP_W-lbgk_pkg::IT_SHIFT-1:0]
                                                              usq,
   input  wire logic [lbgk_pkg::ITEMP_W-1:0]                  itemp,
   input  wire logic [lbgk_pkg::RELAX_W-1:0]                  relax,
   input  wire logic                                          mode,
   output logic signed [lbgk_pkg::FIELD_W-1:0]                new_pop
);
   import lbgk_pkg::*;

   localparam int UQ_W   = 2*FIELD_W + 1 - FRAC_BITS + ITEMP_W - IT_SHIFT;
   localparam int DOT_W  = FIELD_W + 2;
   localparam int PROD_W = DOT_W + ITEMP_W + 1;
   localparam int CU_W   = PROD_W - IT_SHIFT;
   localparam int CC_W   = 2 * CU_W;
   localparam int B_W    = CC_W + 2;
   localparam int P_W    = FIELD_W + 32;
   localparam int A_W    = P_W + 4;
   localparam int QM_W   = T_W + 32;
   localparam int DM_W   = DOT_W + RELAX_W + 1;
   localparam logic signed [1:0] CX = DIR_X[LANE];
   localparam logic signed [1:0] CY = DIR_Y[LANE];
   localparam int WS = W_SHIFT[LANE];

   logic signed [DOT_W-1:0]   dx, dy, dot;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [CU_W-1:0]    cu_ff, cu3_ff;
   logic signed [CC_W-1:0]    cc_ff;
   logic signed [B_W-1:0]     b_ext;
   logic signed [31:0]        b_ff;
   logic signed [P_W-1:0]     p_ff;
   logic signed [A_W-1:0]     pw;
   logic [A_W-1:0]            a_mag, t_full;
   logic [T_W-1:0]            t_ff;
   logic                      neg6_ff, neg7_ff;
   logic [QM_W-1:0]           qm_ff;
   logic [FIELD_W:0]          q;
   logic signed [FIELD_W+1:0] feq_x;
   logic signed [FIELD_W-1:0] feq_ff;
   logic signed [DOT_W-1:0]   diff;
   logic signed [DM_W-1:0]    dm_ff;
   logic signed [FIELD_W-1:0] pop_ff [1:9];
   logic signed [FIELD_W-1:0] rho_ff [1:4];

   // direction dot product, components are -1, 0 or 1
   assign dx  = (CX > 0) ? DOT_W'(ux) : ((CX < 0) ? -DOT_W'(ux) : '0);
   assign dy  = (CY > 0) ? DOT_W'(uy) : ((CY < 0) ? -DOT_W'(uy) : '0);
   assign dot = dx + dy;

   always_comb begin
      if (mode == EQ_LINEAR) begin
         b_ext = (B_W'(1) <<< FRAC_BITS) + B_W'(cu3_ff);
      end else begin
         b_ext = (B_W'(1) <<< FRAC_BITS) + B_W'(cu3_ff)
               + (((B_W'(cc_ff) >>> FRAC_BITS) - $signed(B_W'(usq))) >>> 1);
      end
   end

   assign pw     = A_W'(p_ff) <<< WS;
   assign a_mag  = pw[A_W-1] ? A_W'(-pw) : A_W'(pw);
   assign t_full = a_mag >> (FRAC_BITS + 2);
   assign q      = (FIELD_W+1)'(qm_ff >> RECIP_SHIFT);
   assign feq_x  = neg7_ff ? -$signed({1'b0, q}) : $signed({1'b0, q});
   assign diff   = DOT_W'(pop_ff[8]) - DOT_W'(feq_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         pop_ff[1] <= pop;
         rho_ff[1] <= rho;
         for (int i = 2; i <= 9; i++) begin
            pop_ff[i] <= pop_ff[i-1];
         end
         for (int i = 2; i <= 4; i++) begin
            rho_ff[i] <= rho_ff[i-1];
         end
         prod_ff <= PROD_W'(dot) * $signed({1'b0, itemp});
         cu_ff   <= CU_W'(prod_ff >>> IT_SHIFT);
         cc_ff   <= CC_W'(cu_ff) * CC_W'(cu_ff);
         cu3_ff  <= cu_ff;
         if (b_ext > B_W'(64'sh7FFFFFFF)) begin
            b_ff <= 32'sh7FFFFFFF;
         end else if (b_ext < B_W'(-64'sh80000000)) begin
            b_ff <= -32'sh80000000;
         end else begin
            b_ff <= 32'(b_ext);
         end
         p_ff    <= P_W'(rho_ff[4]) * P_W'(b_ff);
         t_ff    <= (t_full >= A_W'(FEQ_CLIP)) ? FEQ_CLIP : T_W'(t_full);
         neg6_ff <= pw[A_W-1];
         qm_ff   <= QM_W'(t_ff) * QM_W'(RECIP9);
         neg7_ff <= neg6_ff;
         feq_ff  <= sat_field(64'(feq_x));
         dm_ff   <= DM_W'(diff) * $signed({1'b0, relax});
      end
   end

   assign new_pop = sat_field(64'(pop_ff[9]) - 64'(dm_ff >>> NU_SHIFT));

endmodule

`default_nettype wire
